>>> rtl/core/buffer_pool_free_list_allocator_macros.svh
// ----------------------------------------------------------------------------
// Buffer pool free list allocator assertion macros
// Shared concurrent assertion forms, all clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_FREE_LIST_ALLOCATOR_MACROS_SVH
`define BUFFER_POOL_FREE_LIST_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPFL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPFL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bpfl_pkg.sv
// ----------------------------------------------------------------------------
// Buffer pool free list allocator package
// Transaction types, operation and status codes, and shared defaults.
// ----------------------------------------------------------------------------
package bpfl_pkg;

   // Default number of slots the pool storage is built for.
   localparam int SLOTS_DEFAULT = 256;

   // Pool size register value after reset.
   localparam logic [8:0] POOL_SIZE_RESET = 9'd256;

   // Operation codes.
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED   = 2'd1;
   localparam logic [1:0] STATUS_RANGE       = 2'd2;
   localparam logic [1:0] STATUS_NOT_ALLOCED = 2'd3;

   // Request transaction.
   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] slot_index;
   } bpfl_req_type;

   // Response transaction.
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  granted_index;
      logic [8:0]  live_count;
      logic [8:0]  peak_count;
      logic [31:0] exhausted_count;
   } bpfl_rsp_type;

   // List update command from the request logic.
   typedef struct packed {
      logic pop;
      logic push;
   } bpfl_cmd_type;

   // List state seen by the request logic.
   typedef struct packed {
      logic       empty;
      logic       in_range;
      logic       taken;
      logic [7:0] head_index;
   } bpfl_list_status_type;

endpackage

>>> rtl/core/bpfl_list.sv
// ----------------------------------------------------------------------------
// Buffer pool free list storage
// Link table, taken bits, free head and fill mark, with forwarding reads.
// ----------------------------------------------------------------------------
module bpfl_list #(
   parameter int SLOTS = bpfl_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [8:0]                    pool_size,
   input  logic [7:0]                    read_index,
   input  logic [7:0]                    slot_index,
   input  bpfl_pkg::bpfl_cmd_type        cmd,
   output bpfl_pkg::bpfl_list_status_type status
);
   import bpfl_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int HW = $clog2(SLOTS + 1);
   localparam int SW = (HW > 9) ? HW : 9;
   localparam int IW = (HW > 8) ? HW : 8;
   localparam logic [HW-1:0] EMPTY_MARK = HW'(SLOTS);

   // Storage. Entries at or above the fill mark were never written since the
   // last rebuild and read as their rebuilt values instead.
   logic [HW-1:0] link_mem [SLOTS];
   logic          taken_mem [SLOTS];

   logic [HW-1:0] head_ff, head_in;
   logic [HW-1:0] mark_ff, mark_in;
   logic [HW-1:0] link_rd_ff;
   logic          taken_rd_ff;

   logic [HW-1:0] size_n;
   logic [HW-1:0] head_plus;
   logic [HW-1:0] link_next;
   logic          fresh;

   logic          link_we;
   logic [AW-1:0] link_waddr;
   logic [AW-1:0] link_raddr;
   logic          taken_we;
   logic [AW-1:0] taken_waddr;
   logic          taken_wdata;
   logic [AW-1:0] taken_raddr;

   // Effective pool size, saturated to one through SLOTS.
   always_comb begin
      if (pool_size == 9'd0) begin
         size_n = HW'(1);
      end else if (SW'(pool_size) > SW'(SLOTS)) begin
         size_n = EMPTY_MARK;
      end else begin
         size_n = HW'(pool_size);
      end
   end

   // Next free slot after the head, from the table or from the rebuilt chain.
   assign fresh     = (head_ff >= mark_ff);
   assign head_plus = head_ff + HW'(1);
   assign link_next = fresh ? ((head_plus < size_n) ? head_plus : EMPTY_MARK) : link_rd_ff;

   // Status toward the request logic.
   assign status.empty      = (head_ff >= size_n);
   assign status.in_range   = (IW'(slot_index) < IW'(size_n));
   assign status.taken      = (IW'(slot_index) < IW'(mark_ff)) && taken_rd_ff;
   assign status.head_index = 8'(head_ff);

   // Head and fill mark update.
   always_comb begin
      head_in = head_ff;
      mark_in = mark_ff;
      if (cmd.pop) begin
         head_in = link_next;
         if (fresh) begin
            mark_in = mark_ff + HW'(1);
         end
      end else if (cmd.push) begin
         head_in = HW'(slot_index);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         head_ff <= '0;
         mark_ff <= '0;
      end else begin
         head_ff <= head_in;
         mark_ff <= mark_in;
      end
   end

   // Memory ports.
   assign link_we     = cmd.push;
   assign link_waddr  = AW'(slot_index);
   assign link_raddr  = AW'(head_in);
   assign taken_we    = cmd.pop || cmd.push;
   assign taken_waddr = cmd.pop ? AW'(head_ff) : AW'(slot_index);
   assign taken_wdata = cmd.pop;
   assign taken_raddr = AW'(read_index);

   // Link table: the read follows the next head, forwarding a write to it.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= head_ff;
      end
      if (link_we && (link_waddr == link_raddr)) begin
         link_rd_ff <= head_ff;
      end else begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

   // Taken bits: the read follows the incoming request, forwarding a write.
   always_ff @(posedge clock) begin
      if (taken_we) begin
         taken_mem[taken_waddr] <= taken_wdata;
      end
      if (taken_we && (taken_waddr == taken_raddr)) begin
         taken_rd_ff <= taken_wdata;
      end else begin
         taken_rd_ff <= taken_mem[taken_raddr];
      end
   end

endmodule

>>> rtl/core/buffer_pool_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Buffer pool free list allocator
// LIFO free list of buffer slots with allocate, free and check transactions.
// ----------------------------------------------------------------------------
// A transaction is taken at each clock edge where start is high and busy is
// low, one per cycle with no gaps. It is held in the request register, where
// the registered link and taken-bit memory reads are used, and its result
// is loaded into the result register at the next edge. The result then
// stays on rsp_payload with rsp_valid for exactly one cycle. The receiver
// cannot stall, so results must be consumed as they come. Busy is high while
// reset is asserted and until the first clock edge after it is released. A
// write of csr_write_data reloads the pool size and rebuilds the free list at
// that same edge with no clearing pass, because a fill mark stands in for the
// untouched table entries; it must only be issued while no result is due.
// ----------------------------------------------------------------------------
`include "buffer_pool_free_list_allocator_macros.svh"

module buffer_pool_free_list_allocator #(
   parameter int SLOTS = bpfl_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bpfl_pkg::bpfl_req_type req_payload,
   output logic                   rsp_valid,
   output bpfl_pkg::bpfl_rsp_type rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [8:0]             csr_write_data
);
   import bpfl_pkg::*;

   logic                 busy_ff;
   logic                 accept;
   logic                 in_valid_ff;
   bpfl_req_type         in_req_ff;
   logic [8:0]           pool_size_ff;
   logic [8:0]           live_ff, live_in;
   logic [8:0]           peak_ff, peak_in;
   logic [31:0]          refusal_ff, refusal_in;
   logic                 rsp_valid_ff;
   bpfl_rsp_type         rsp_payload_ff;
   bpfl_rsp_type         result_in;
   bpfl_cmd_type         cmd;
   bpfl_list_status_type list_status;

   assign accept = start && !busy_ff;

   // Busy only while coming out of reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= req_payload;
      end
   end

   // Free list storage.
   bpfl_list #(
      .SLOTS(SLOTS)
   ) u_list (
      .clock      (clock),
      .reset      (reset),
      .clear      (csr_write_enable),
      .pool_size  (pool_size_ff),
      .read_index (req_payload.slot_index),
      .slot_index (in_req_ff.slot_index),
      .cmd        (cmd),
      .status     (list_status)
   );

   // Decode the transaction in the request register.
   always_comb begin
      cmd        = '0;
      live_in    = live_ff;
      peak_in    = peak_ff;
      refusal_in = refusal_ff;
      result_in  = '0;
      if (in_valid_ff) begin
         case (in_req_ff.operation)
            OP_ALLOC: begin
               if (list_status.empty) begin
                  result_in.status = STATUS_EXHAUSTED;
                  refusal_in       = refusal_ff + 32'd1;
               end else begin
                  cmd.pop                 = 1'b1;
                  result_in.granted_index = list_status.head_index;
                  live_in                 = live_ff + 9'd1;
                  if (live_in > peak_ff) begin
                     peak_in = live_in;
                  end
               end
            end
            OP_FREE, OP_CHECK: begin
               if (!list_status.in_range) begin
                  result_in.status = STATUS_RANGE;
               end else if (!list_status.taken) begin
                  result_in.status = STATUS_NOT_ALLOCED;
               end else if (in_req_ff.operation == OP_FREE) begin
                  cmd.push = 1'b1;
                  if (live_ff != 9'd0) begin
                     live_in = live_ff - 9'd1;
                  end
               end
            end
            default: begin
               result_in = '0;
            end
         endcase
      end
      result_in.live_count      = live_in;
      result_in.peak_count      = peak_in;
      result_in.exhausted_count = refusal_in;
   end

   // Pool size register and counters; a size write restarts them.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= POOL_SIZE_RESET;
         live_ff      <= '0;
         peak_ff      <= '0;
         refusal_ff   <= '0;
      end else if (csr_write_enable) begin
         pool_size_ff <= csr_write_data;
         live_ff      <= '0;
         peak_ff      <= '0;
         refusal_ff   <= '0;
      end else begin
         live_ff    <= live_in;
         peak_ff    <= peak_in;
         refusal_ff <= refusal_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         rsp_payload_ff <= result_in;
      end
   end

   assign busy        = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Every transaction in the request register yields exactly one result in the next cycle.
   `BPFL_ASSERT_NEXT(a_result_follows, in_valid_ff, rsp_valid_ff, "result missing")
   `BPFL_ASSERT_NEXT(a_no_stray_result, !in_valid_ff, !rsp_valid_ff, "result without request")
   // The live count never runs ahead of its peak.
   `BPFL_ASSERT_SAME(a_live_le_peak, 1'b1, live_ff <= peak_ff, "live count above peak")
   // The refusal counter moves only on an allocate against an empty list or a pool size write.
   `BPFL_ASSERT_NEXT(a_refusal_hold,
      !(in_valid_ff && (in_req_ff.operation == OP_ALLOC) && list_status.empty)
      && !csr_write_enable,
      $stable(refusal_ff), "refusal count changed without refusal")

endmodule

>>> tb/sv/pool_result_checker.sv
// ----------------------------------------------------------------------------
// Free list allocator result checker
// Watches the request, result and pool size ports of the allocator, keeps its
// own copy of the free list, predicts each result and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module pool_result_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  bpfl_pkg::bpfl_req_type req_payload,
   input  logic                   rsp_valid,
   input  bpfl_pkg::bpfl_rsp_type rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [8:0]             csr_write_data,
   output int                     mismatch_total,
   output int                     pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import bpfl_pkg::*;

   localparam int         POOL_SLOTS = SLOTS_DEFAULT;
   localparam logic [8:0] LIST_END   = 9'(POOL_SLOTS);

   // Shadow copy of the pool state.
   logic [8:0]   link_table [POOL_SLOTS];
   logic         slot_in_use [POOL_SLOTS];
   logic [8:0]   head_slot;
   logic [8:0]   in_use_count;
   logic [8:0]   high_water;
   logic [31:0]  refusal_count;
   logic [8:0]   size_setting;

   // Results predicted for accepted transactions, oldest first.
   bpfl_rsp_type due_results [$];

   // The register value saturates to the range of slots that exist.
   function automatic int active_size();
      if (size_setting == 9'd0) return 1;
      if (size_setting > 9'(POOL_SLOTS)) return POOL_SLOTS;
      return int'(size_setting);
   endfunction

   // A pool size write rebuilds the shadow pool as reset does, with the new size.
   function automatic void rebuild_pool(input logic [8:0] setting);
      int n;
      size_setting = setting;
      n = active_size();
      for (int i = 0; i < POOL_SLOTS; i++) begin
         link_table[i]  = (i + 1 < n) ? 9'(i + 1) : LIST_END;
         slot_in_use[i] = 1'b0;
      end
      head_slot     = 9'd0;
      in_use_count  = 9'd0;
      high_water    = 9'd0;
      refusal_count = 32'd0;
   endfunction

   // Applies one transaction to the shadow pool and returns its result.
   function automatic bpfl_rsp_type apply_request(input bpfl_req_type r);
      bpfl_rsp_type outcome;
      int           n;
      logic [8:0]   slot;
      outcome = '0;
      n = active_size();
      slot = {1'b0, r.slot_index};
      case (r.operation)
         OP_ALLOC: begin
            if (head_slot >= 9'(n)) begin
               outcome.status = STATUS_EXHAUSTED;
               refusal_count  = refusal_count + 32'd1;
            end else begin
               outcome.granted_index       = head_slot[7:0];
               slot_in_use[head_slot[7:0]] = 1'b1;
               head_slot                   = link_table[head_slot[7:0]];
               in_use_count                = in_use_count + 9'd1;
               if (in_use_count > high_water) high_water = in_use_count;
            end
         end
         OP_FREE, OP_CHECK: begin
            if (slot >= 9'(n)) begin
               outcome.status = STATUS_RANGE;
            end else if (!slot_in_use[slot[7:0]]) begin
               outcome.status = STATUS_NOT_ALLOCED;
            end else if (r.operation == OP_FREE) begin
               // The freed slot goes back on top of the list.
               slot_in_use[slot[7:0]] = 1'b0;
               link_table[slot[7:0]]  = head_slot;
               head_slot              = slot;
               if (in_use_count > 9'd0) in_use_count = in_use_count - 9'd1;
            end
         end
         default: begin
            // The unused operation code leaves the pool untouched.
         end
      endcase
      outcome.live_count      = in_use_count;
      outcome.peak_count      = high_water;
      outcome.exhausted_count = refusal_count;
      return outcome;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatch_total++;
      end
   endfunction

   // Results are retired before a new transaction is predicted, since a new
   // transaction never has its result in the same cycle.
   always @(posedge clock) begin
      bpfl_rsp_type want;
      if (reset) begin
         rebuild_pool(POOL_SIZE_RESET);
         due_results.delete();
         mismatch_total = 0;
      end else begin
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               $error("result seen with no transaction outstanding");
               mismatch_total++;
            end else begin
               want = due_results.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_payload.status));
               compare_field("granted_index", 32'(want.granted_index),
                             32'(rsp_payload.granted_index));
               compare_field("live_count", 32'(want.live_count),
                             32'(rsp_payload.live_count));
               compare_field("peak_count", 32'(want.peak_count),
                             32'(rsp_payload.peak_count));
               compare_field("exhausted_count", want.exhausted_count,
                             rsp_payload.exhausted_count);
            end
         end
         if (csr_write_enable) rebuild_pool(csr_write_data);
         if (start && !busy) due_results.push_back(apply_request(req_payload));
      end
      pending_results = due_results.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Free list allocator testbench
// Drives directed and random allocate, free and check transactions through
// several pool sizes, with random gaps between requests, while the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpfl_pkg::*;

   localparam int         CLOCK_PERIOD   = 8;
   localparam int         RESET_CYCLES   = 6;
   localparam int         SETTLE_CYCLES  = 4;
   localparam int         WATCHDOG_LIMIT = 400;
   localparam int         PHASES         = 8;
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   bpfl_req_type req_payload;
   logic         rsp_valid;
   bpfl_rsp_type rsp_payload;
   logic         csr_write_enable;
   logic [8:0]   csr_write_data;
   int           mismatch_total;
   int           pending_results;
   int           items_sent;
   int           sizes_written;

   // Pool sizes, lengths and allocate share of the random phases.
   logic [8:0] phase_size  [PHASES] = '{9'd1, 9'd3, 9'd17, 9'd511, 9'd64, 9'd0,
                                        9'd100, 9'd256};
   int         phase_len   [PHASES] = '{60, 80, 120, 340, 150, 40, 120, 100};
   int         phase_alloc [PHASES] = '{50, 60, 55, 90, 60, 50, 45, 55};

   buffer_pool_free_list_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   pool_result_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_total   (mismatch_total),
      .pending_results  (pending_results)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Idles for the given number of cycles, or for a randomly drawn gap when negative,
   // then holds one transaction until it is accepted.
   task automatic send(input logic [1:0] op, input logic [7:0] idx, input int gap = -1);
      int wait_cycles;
      wait_cycles = (gap < 0) ? int'($urandom_range(0, 9)) : gap;
      repeat (wait_cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= '{operation: op, slot_index: idx};
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // Stops requests and waits until every predicted result has come back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_pool_size(input logic [8:0] value);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sizes_written++;
   endtask

   // Random traffic for one pool size. Frees and checks mostly aim at low
   // slots, where a fresh list hands out its grants, so they usually hit live
   // allocations; a tenth of them use any index.
   task automatic random_phase(input logic [8:0] setting, input int count,
                               input int alloc_pct);
      int span;
      int grants;
      int roll;
      int gap;
      int hi;
      int pick;
      write_pool_size(setting);
      span   = (setting == 9'd0) ? 1 : ((setting > 9'd256) ? 256 : int'(setting));
      grants = 0;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         gap  = (k >= count / 3 && k < count / 2) ? 0 : int'($urandom_range(0, 9));
         if (roll < alloc_pct) begin
            send(OP_ALLOC, 8'($urandom_range(0, 255)), gap);
            grants++;
         end else if (roll < 97) begin
            hi   = (grants < span - 1) ? grants : span - 1;
            pick = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 255))
                                               : int'($urandom_range(0, hi));
            send(($urandom_range(0, 2) == 0) ? OP_CHECK : OP_FREE, 8'(pick), gap);
         end else begin
            send(OP_UNUSED, 8'($urandom_range(0, 255)), gap);
         end
      end
   endtask

   // Ends the run when nothing has been accepted or returned for too long.
   initial begin
      int idle_count;
      idle_count = 0;
      while (idle_count < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) idle_count = 0;
         else idle_count++;
      end
      $display("buffer_pool_free_list_allocator verification failed");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      items_sent       = 0;
      sizes_written    = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Full pool after reset: empty checks and frees, the unused code,
      // LIFO reuse of a freed slot, and the top index.
      send(OP_CHECK, 8'd0, 0);
      send(OP_FREE, 8'd0);
      send(OP_UNUSED, 8'hFF, 0);
      send(OP_ALLOC, 8'hFF, 0);
      send(OP_ALLOC, 8'h00);
      send(OP_ALLOC, 8'hAA, 0);
      send(OP_CHECK, 8'd1);
      send(OP_FREE, 8'd1, 0);
      send(OP_ALLOC, 8'h55);
      send(OP_CHECK, 8'd255, 0);
      send(OP_FREE, 8'd255);

      // Two slots: exhaustion, indexes out of range, reuse after a free.
      write_pool_size(9'd2);
      send(OP_ALLOC, 8'd0, 0);
      send(OP_ALLOC, 8'd0, 0);
      send(OP_ALLOC, 8'd0);
      send(OP_CHECK, 8'd2, 0);
      send(OP_FREE, 8'hFF);
      send(OP_FREE, 8'd0, 0);
      send(OP_ALLOC, 8'd0);
      send(OP_UNUSED, 8'd0, 0);

      // A size of zero saturates to one slot; the second free is a double free.
      write_pool_size(9'd0);
      send(OP_ALLOC, 8'd0);
      send(OP_ALLOC, 8'd0, 0);
      send(OP_CHECK, 8'd1);
      send(OP_FREE, 8'd0, 0);
      send(OP_FREE, 8'd0, 0);

      phase_size[6] = 9'($urandom_range(2, 255));
      for (int p = 0; p < PHASES; p++) random_phase(phase_size[p], phase_len[p], phase_alloc[p]);

      drain();
      $display("Run covered %0d transactions over %0d pool size settings,", items_sent,
               sizes_written);
      $display("including sizes 0, 1 and 511 and a full pool driven to exhaustion.");
      if (mismatch_total == 0 && pending_results == 0) begin
         $display("buffer_pool_free_list_allocator verification clean");
      end else begin
         $display("buffer_pool_free_list_allocator verification failed");
      end
      $finish;
   end

endmodule
